// ----- rtl/rbrm_pkg.sv -----
`default_nettype none

package rbrm_pkg;

    // ring geometry
    localparam int unsigned RING_BYTES = 4096;

    // field widths
    localparam int CNT_W  = 13;
    localparam int PTR_W  = 12;
    localparam int PROD_W = 2 * CNT_W;
    localparam int ACT_W  = 3;
    localparam int STAT_W = 2;

    // serial divider: one quotient bit per cycle
    localparam int DIV_STEPS = CNT_W;
    localparam int DIV_CNT_W = $clog2(DIV_STEPS);

    localparam logic [CNT_W-1:0] RING_MAX = CNT_W'(RING_BYTES);

    // command codes
    localparam logic [ACT_W-1:0] ACT_RSV_WR    = 3'd0;
    localparam logic [ACT_W-1:0] ACT_RSV_RD    = 3'd1;
    localparam logic [ACT_W-1:0] ACT_COMMIT_WR = 3'd2;
    localparam logic [ACT_W-1:0] ACT_FREE_RD   = 3'd3;
    localparam logic [ACT_W-1:0] ACT_SET_EOS   = 3'd4;

    // result status codes
    localparam logic [STAT_W-1:0] STAT_OK    = 2'd0;
    localparam logic [STAT_W-1:0] STAT_RETRY = 2'd1;
    localparam logic [STAT_W-1:0] STAT_EOS   = 2'd2;
    localparam logic [STAT_W-1:0] STAT_ERR   = 2'd3;

    // controller to datapath
    typedef struct packed {
        logic load;
        logic mul_a;
        logic div_init;
        logic div_step;
        logic mul_b;
        logic finish;
    } dp_cmd_t;

    // datapath to controller
    typedef struct packed {
        logic need_div;
        logic div_last;
        logic out_free;
    } dp_stat_t;

endpackage

`default_nettype wire

// ----- rtl/rbrm_div.sv -----
`default_nettype none

module rbrm_div (
    input  wire                            aclk,
    input  wire                            aresetn,
    input  wire                            start,
    input  wire                            step,
    input  wire  [rbrm_pkg::CNT_W-1:0]     dividend,
    input  wire  [rbrm_pkg::CNT_W-1:0]     divisor,
    output logic [rbrm_pkg::CNT_W-1:0]     quotient,
    output logic                           last
);

    logic [rbrm_pkg::CNT_W-1:0]     rem_reg, rem_next;
    logic [rbrm_pkg::CNT_W-1:0]     quo_reg, quo_next;
    logic [rbrm_pkg::DIV_CNT_W-1:0] cnt_reg, cnt_next;
    logic [rbrm_pkg::CNT_W:0]       shifted;
    logic [rbrm_pkg::CNT_W:0]       diff;

    // restoring division, one bit per step
    always_comb begin
        shifted  = {rem_reg, quo_reg[rbrm_pkg::CNT_W-1]};
        diff     = shifted - {1'b0, divisor};
        rem_next = rem_reg;
        quo_next = quo_reg;
        cnt_next = cnt_reg;
        if (start) begin
            rem_next = '0;
            quo_next = dividend;
            cnt_next = rbrm_pkg::DIV_CNT_W'(rbrm_pkg::DIV_STEPS - 1);
        end else if (step) begin
            if (shifted >= {1'b0, divisor}) begin
                rem_next = diff[rbrm_pkg::CNT_W-1:0];
                quo_next = {quo_reg[rbrm_pkg::CNT_W-2:0], 1'b1};
            end else begin
                rem_next = shifted[rbrm_pkg::CNT_W-1:0];
                quo_next = {quo_reg[rbrm_pkg::CNT_W-2:0], 1'b0};
            end
            cnt_next = cnt_reg - 1'b1;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cnt_reg <= '0;
        end else begin
            cnt_reg <= cnt_next;
        end
        rem_reg <= rem_next;
        quo_reg <= quo_next;
    end

    assign quotient = quo_reg;
    assign last     = (cnt_reg == '0);

endmodule

`default_nettype wire

// ----- rtl/rbrm_dp.sv -----
`default_nettype none

module rbrm_dp (
    input  wire                               aclk,
    input  wire                               aresetn,
    // ring size register
    input  wire                               cfg_valid,
    input  wire  [rbrm_pkg::CNT_W-1:0]        cfg_data,
    // command fields
    input  wire  [rbrm_pkg::ACT_W-1:0]        s_action,
    input  wire  [rbrm_pkg::CNT_W-1:0]        s_min_units,
    input  wire  [rbrm_pkg::CNT_W-1:0]        s_max_units,
    input  wire  [rbrm_pkg::CNT_W-1:0]        s_unit_bytes,
    input  wire  [rbrm_pkg::CNT_W-1:0]        s_reserved_units,
    input  wire  [rbrm_pkg::CNT_W-1:0]        s_done_units,
    // control
    input  wire  rbrm_pkg::dp_cmd_t           cmd,
    output rbrm_pkg::dp_stat_t                stat,
    // result
    output logic                              m_valid,
    input  wire                               m_ready,
    output logic [rbrm_pkg::STAT_W-1:0]       m_status,
    output logic [rbrm_pkg::PTR_W-1:0]        m_region_offset,
    output logic [rbrm_pkg::CNT_W-1:0]        m_units_granted,
    output logic [rbrm_pkg::CNT_W-1:0]        m_fill_bytes
);

    localparam int CW = rbrm_pkg::CNT_W;
    localparam int PW = rbrm_pkg::PTR_W;

    // latched command
    logic [rbrm_pkg::ACT_W-1:0]  act_reg;
    logic [CW-1:0]               mn_reg, mx_reg, ub_reg, orig_reg, done_reg;

    // products
    logic [rbrm_pkg::PROD_W-1:0] prod_a_reg;
    logic [CW-1:0]               prod_b_reg;
    logic [CW-1:0]               mul_op;
    logic [rbrm_pkg::PROD_W-1:0] product;

    // ring state
    logic [CW-1:0] ring_reg, ring_next;
    logic [PW-1:0] rptr_reg, rptr_next;
    logic [PW-1:0] wptr_reg, wptr_next;
    logic [CW-1:0] held_reg, held_next;
    logic [CW-1:0] wres_reg, wres_next;
    logic [CW-1:0] rres_reg, rres_next;
    logic          end_reg, end_next;

    // result register
    logic                        valid_reg, valid_next;
    logic [rbrm_pkg::STAT_W-1:0] st_reg, st_next;
    logic [PW-1:0]               off_reg, off_next;
    logic [CW-1:0]               gr_reg, gr_next;
    logic [CW-1:0]               fill_reg, fill_next;

    // derived quantities
    logic [CW:0]   used;
    logic [CW-1:0] space, wroom, rroom, data, avail, room, lim, dividend;
    logic [CW-1:0] quotient;
    logic          div_last;
    logic          is_rsv;
    logic          err_early;
    logic [CW-1:0] wsum, rsum, cfg_clamped;
    logic [CW-1:0] fin_st_held, fin_st_wres, fin_st_rres;
    logic [PW-1:0] fin_wptr, fin_rptr;
    logic          fin_end;
    logic [rbrm_pkg::STAT_W-1:0] fin_st;
    logic [PW-1:0] fin_off;
    logic [CW-1:0] fin_gr;

    assign is_rsv = (act_reg == rbrm_pkg::ACT_RSV_WR) || (act_reg == rbrm_pkg::ACT_RSV_RD);

    // free space, contiguous room and unreserved data
    always_comb begin
        used  = {1'b0, held_reg} + {1'b0, wres_reg};
        space = (used < {1'b0, ring_reg}) ? CW'({1'b0, ring_reg} - used) : '0;
        wroom = ({1'b0, wptr_reg} < ring_reg) ? ring_reg - {1'b0, wptr_reg} : '0;
        rroom = ({1'b0, rptr_reg} < ring_reg) ? ring_reg - {1'b0, rptr_reg} : '0;
        data  = (held_reg > rres_reg) ? held_reg - rres_reg : '0;
        avail = (act_reg == rbrm_pkg::ACT_RSV_WR) ? space : data;
        room  = (act_reg == rbrm_pkg::ACT_RSV_WR) ? wroom : rroom;
        lim   = (avail < room) ? avail : room;
        dividend = (prod_a_reg > {{CW{1'b0}}, lim}) ? lim : prod_a_reg[CW-1:0];
    end

    // shared multiplier
    always_comb begin
        if (cmd.mul_b) begin
            mul_op = is_rsv ? quotient : done_reg;
        end else if (is_rsv) begin
            mul_op = mx_reg;
        end else if (act_reg == rbrm_pkg::ACT_COMMIT_WR) begin
            mul_op = orig_reg;
        end else begin
            mul_op = done_reg;
        end
        product = mul_op * ub_reg;
    end

    rbrm_div u_div (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .start    (cmd.div_init),
        .step     (cmd.div_step),
        .dividend (dividend),
        .divisor  (ub_reg),
        .quotient (quotient),
        .last     (div_last)
    );

    // outcome of the command, from the latched operands and products
    always_comb begin
        err_early = (act_reg > rbrm_pkg::ACT_SET_EOS)
                 || ((act_reg <= rbrm_pkg::ACT_FREE_RD) && (ub_reg == '0))
                 || ((act_reg <= rbrm_pkg::ACT_RSV_RD) && (mn_reg > mx_reg));
        wsum = {1'b0, wptr_reg} + prod_b_reg;
        rsum = {1'b0, rptr_reg} + prod_b_reg;
        fin_st      = rbrm_pkg::STAT_OK;
        fin_off     = '0;
        fin_gr      = '0;
        fin_wptr    = wptr_reg;
        fin_rptr    = rptr_reg;
        fin_st_held = held_reg;
        fin_st_wres = wres_reg;
        fin_st_rres = rres_reg;
        fin_end     = end_reg;
        if (err_early) begin
            fin_st = rbrm_pkg::STAT_ERR;
        end else begin
            case (act_reg)
                rbrm_pkg::ACT_RSV_WR: begin
                    if ((quotient == '0) || (quotient < mn_reg)) begin
                        fin_st = rbrm_pkg::STAT_RETRY;
                    end else begin
                        fin_off     = wptr_reg;
                        fin_gr      = quotient;
                        fin_wptr    = PW'((wsum >= ring_reg) ? wsum - ring_reg : wsum);
                        fin_st_wres = wres_reg + prod_b_reg;
                    end
                end
                rbrm_pkg::ACT_RSV_RD: begin
                    if ((data == '0) || (quotient == '0)) begin
                        fin_st = end_reg ? rbrm_pkg::STAT_EOS : rbrm_pkg::STAT_RETRY;
                    end else if (!end_reg && (quotient < mn_reg)) begin
                        fin_st = rbrm_pkg::STAT_RETRY;
                    end else begin
                        fin_off     = rptr_reg;
                        fin_gr      = quotient;
                        fin_rptr    = PW'((rsum >= ring_reg) ? rsum - ring_reg : rsum);
                        fin_st_rres = rres_reg + prod_b_reg;
                    end
                end
                rbrm_pkg::ACT_COMMIT_WR: begin
                    // prod_a is the reserved byte count, prod_b the written one
                    if ((done_reg > orig_reg) || (prod_a_reg > {{CW{1'b0}}, wres_reg})) begin
                        fin_st = rbrm_pkg::STAT_ERR;
                    end else begin
                        fin_st_wres = wres_reg - prod_a_reg[CW-1:0];
                        fin_st_held = held_reg + prod_b_reg;
                    end
                end
                rbrm_pkg::ACT_FREE_RD: begin
                    if (done_reg != '0) begin
                        if ((prod_a_reg > {{CW{1'b0}}, rres_reg})
                            || (prod_a_reg > {{CW{1'b0}}, held_reg})) begin
                            fin_st = rbrm_pkg::STAT_ERR;
                        end else begin
                            fin_st_rres = rres_reg - prod_a_reg[CW-1:0];
                            fin_st_held = held_reg - prod_a_reg[CW-1:0];
                        end
                    end
                end
                rbrm_pkg::ACT_SET_EOS: begin
                    if (wres_reg != '0) begin
                        fin_st = rbrm_pkg::STAT_ERR;
                    end else begin
                        fin_end = 1'b1;
                    end
                end
                default: begin
                    fin_st = rbrm_pkg::STAT_ERR;
                end
            endcase
        end
    end

    // next state of ring and result register
    always_comb begin
        cfg_clamped = (cfg_data == '0) ? CW'(1)
                    : ((cfg_data > rbrm_pkg::RING_MAX) ? rbrm_pkg::RING_MAX : cfg_data);
        ring_next = ring_reg;
        rptr_next = rptr_reg;
        wptr_next = wptr_reg;
        held_next = held_reg;
        wres_next = wres_reg;
        rres_next = rres_reg;
        end_next  = end_reg;
        valid_next = valid_reg && !m_ready;
        st_next   = st_reg;
        off_next  = off_reg;
        gr_next   = gr_reg;
        fill_next = fill_reg;
        if (cfg_valid) begin
            ring_next = cfg_clamped;
            rptr_next = '0;
            wptr_next = '0;
            held_next = '0;
            wres_next = '0;
            rres_next = '0;
            end_next  = 1'b0;
        end else if (cmd.finish) begin
            rptr_next = fin_rptr;
            wptr_next = fin_wptr;
            held_next = fin_st_held;
            wres_next = fin_st_wres;
            rres_next = fin_st_rres;
            end_next  = fin_end;
        end
        if (cmd.finish) begin
            valid_next = 1'b1;
            st_next    = fin_st;
            off_next   = fin_off;
            gr_next    = fin_gr;
            fill_next  = fin_st_held;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            ring_reg  <= rbrm_pkg::RING_MAX;
            rptr_reg  <= '0;
            wptr_reg  <= '0;
            held_reg  <= '0;
            wres_reg  <= '0;
            rres_reg  <= '0;
            end_reg   <= 1'b0;
            valid_reg <= 1'b0;
        end else begin
            ring_reg  <= ring_next;
            rptr_reg  <= rptr_next;
            wptr_reg  <= wptr_next;
            held_reg  <= held_next;
            wres_reg  <= wres_next;
            rres_reg  <= rres_next;
            end_reg   <= end_next;
            valid_reg <= valid_next;
        end
        st_reg   <= st_next;
        off_reg  <= off_next;
        gr_reg   <= gr_next;
        fill_reg <= fill_next;
    end

    // operand capture and products
    always_ff @(posedge aclk) begin
        if (cmd.load) begin
            act_reg  <= s_action;
            mn_reg   <= (s_min_units == '0) ? CW'(1) : s_min_units;
            mx_reg   <= (s_max_units == '0) ? CW'(1) : s_max_units;
            ub_reg   <= s_unit_bytes;
            orig_reg <= s_reserved_units;
            done_reg <= s_done_units;
        end
        if (cmd.mul_a) begin
            prod_a_reg <= product;
        end
        if (cmd.mul_b) begin
            prod_b_reg <= product[CW-1:0];
        end
    end

    assign stat.need_div = is_rsv;
    assign stat.div_last = div_last;
    assign stat.out_free = !valid_reg || m_ready;

    assign m_valid         = valid_reg;
    assign m_status        = st_reg;
    assign m_region_offset = off_reg;
    assign m_units_granted = gr_reg;
    assign m_fill_bytes    = fill_reg;

endmodule

`default_nettype wire

// ----- rtl/rbrm_ctrl.sv -----
`default_nettype none

module rbrm_ctrl (
    input  wire                       aclk,
    input  wire                       aresetn,
    input  wire                       s_valid,
    output logic                      s_ready,
    input  wire  rbrm_pkg::dp_stat_t  stat,
    output rbrm_pkg::dp_cmd_t         cmd
);

    typedef enum logic [5:0] {
        S_IDLE     = 6'b000001,
        S_MUL_A    = 6'b000010,
        S_DIV_INIT = 6'b000100,
        S_DIV      = 6'b001000,
        S_MUL_B    = 6'b010000,
        S_FINISH   = 6'b100000
    } state_t;

    state_t state_reg, state_next;

    always_comb begin
        state_next = state_reg;
        cmd        = '0;
        s_ready    = 1'b0;
        case (state_reg)
            S_IDLE: begin
                s_ready = 1'b1;
                if (s_valid) begin
                    cmd.load   = 1'b1;
                    state_next = S_MUL_A;
                end
            end
            S_MUL_A: begin
                cmd.mul_a  = 1'b1;
                state_next = stat.need_div ? S_DIV_INIT : S_MUL_B;
            end
            S_DIV_INIT: begin
                cmd.div_init = 1'b1;
                state_next   = S_DIV;
            end
            S_DIV: begin
                cmd.div_step = 1'b1;
                if (stat.div_last) begin
                    state_next = S_MUL_B;
                end
            end
            S_MUL_B: begin
                cmd.mul_b  = 1'b1;
                state_next = S_FINISH;
            end
            S_FINISH: begin
                // wait for room in the result register
                if (stat.out_free) begin
                    cmd.finish = 1'b1;
                    state_next = S_IDLE;
                end
            end
            default: begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= S_IDLE;
        end else begin
            state_reg <= state_next;
        end
    end

endmodule

`default_nettype wire

// ----- rtl/ring_buffer_reservation_manager_core.sv -----
// pointer and occupancy manager for a byte ring with one producer and one consumer
// s_ channel: one command per transfer (reserve write/read, commit write,
//   free read, set end of stream) with its unit size and unit counts
// m_ channel: one result per command: status, region offset, units granted
//   and the committed byte count held after the command
// cfg channel: writes the ring size (clamped to 1..4096) and clears all
//   pointers and counts; cfg_ready is always high, write only while idle
// reserve commands run a 13-step serial divider (bytes available / unit size)
//   between the two multiplies; the next command is taken once the result
//   has been written into the output register
// commit, free, end of stream and rejected codes skip the divider; the shared
//   13x13 multiplier runs twice per command
// one command is in work at a time; the finished result sits in an output
//   register, so a new command is accepted while the receiver stalls
// if a second result is ready before the first is taken, the block holds it
//   until m_ready frees the output register
// reset (aresetn low, synchronous): ring size 4096, pointers and counts zero,
//   end of stream clear, no result pending
`default_nettype none

module ring_buffer_reservation_manager_core (
    input  wire                               aclk,
    input  wire                               aresetn,
    // ring size register
    input  wire                               cfg_valid,
    output logic                              cfg_ready,
    input  wire  [rbrm_pkg::CNT_W-1:0]        cfg_data,
    // command channel
    input  wire                               s_valid,
    output logic                              s_ready,
    input  wire  [rbrm_pkg::ACT_W-1:0]        s_action,
    input  wire  [rbrm_pkg::CNT_W-1:0]        s_min_units,
    input  wire  [rbrm_pkg::CNT_W-1:0]        s_max_units,
    input  wire  [rbrm_pkg::CNT_W-1:0]        s_unit_bytes,
    input  wire  [rbrm_pkg::CNT_W-1:0]        s_reserved_units,
    input  wire  [rbrm_pkg::CNT_W-1:0]        s_done_units,
    // result channel
    output logic                              m_valid,
    input  wire                               m_ready,
    output logic [rbrm_pkg::STAT_W-1:0]       m_status,
    output logic [rbrm_pkg::PTR_W-1:0]        m_region_offset,
    output logic [rbrm_pkg::CNT_W-1:0]        m_units_granted,
    output logic [rbrm_pkg::CNT_W-1:0]        m_fill_bytes
);

    rbrm_pkg::dp_cmd_t  cmd;
    rbrm_pkg::dp_stat_t stat;

    // ring size writes are taken in any cycle
    assign cfg_ready = 1'b1;

    // sequencer: one command at a time through multiply, divide (reserves only), multiply, update
    rbrm_ctrl u_ctrl (
        .aclk    (aclk),
        .aresetn (aresetn),
        .s_valid (s_valid),
        .s_ready (s_ready),
        .stat    (stat),
        .cmd     (cmd)
    );

    // pointers, counts, shared multiplier, divider and result register
    rbrm_dp u_dp (
        .aclk             (aclk),
        .aresetn          (aresetn),
        .cfg_valid        (cfg_valid),
        .cfg_data         (cfg_data),
        .s_action         (s_action),
        .s_min_units      (s_min_units),
        .s_max_units      (s_max_units),
        .s_unit_bytes     (s_unit_bytes),
        .s_reserved_units (s_reserved_units),
        .s_done_units     (s_done_units),
        .cmd              (cmd),
        .stat             (stat),
        .m_valid          (m_valid),
        .m_ready          (m_ready),
        .m_status         (m_status),
        .m_region_offset  (m_region_offset),
        .m_units_granted  (m_units_granted),
        .m_fill_bytes     (m_fill_bytes)
    );

endmodule

`default_nettype wire

// ----- rtl/rbrm_checker.sv -----
`default_nettype none

module rbrm_checker (
    input wire                          aclk,
    input wire                          aresetn,
    input wire                          s_valid,
    input wire                          s_ready,
    input wire                          m_valid,
    input wire                          m_ready,
    input wire [rbrm_pkg::STAT_W-1:0]   m_status,
    input wire [rbrm_pkg::PTR_W-1:0]    m_region_offset,
    input wire [rbrm_pkg::CNT_W-1:0]    m_units_granted,
    input wire [rbrm_pkg::CNT_W-1:0]    m_fill_bytes
);

    // no result pending right after reset
    a_reset_empty: assert property (@(posedge aclk)
        !aresetn |=> !m_valid)
        else $error("result pending after reset");

    // a stalled result holds
    a_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && !m_ready |=> m_valid && $stable(m_status)
            && $stable(m_region_offset) && $stable(m_units_granted)
            && $stable(m_fill_bytes))
        else $error("stalled result changed");

    // one command in work at a time
    a_one_cmd: assert property (@(posedge aclk) disable iff (!aresetn)
        s_valid && s_ready |=> !s_ready)
        else $error("command taken while busy");

    // a result that is not OK reports no region
    a_no_region: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && (m_status != rbrm_pkg::STAT_OK)
            |-> (m_units_granted == '0) && (m_region_offset == '0))
        else $error("region reported without grant");

    // reported held data never exceeds the largest ring size
    a_fill_bound: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid |-> (m_fill_bytes <= rbrm_pkg::RING_MAX))
        else $error("fill beyond ring size");

endmodule

bind ring_buffer_reservation_manager_core rbrm_checker u_rbrm_checker (.*);

`default_nettype wire
